[design/fqv_pkg.sv]
// Shared types and constants for the FASTQ record validator.
`timescale 1ns / 1ps

package fqv_pkg;

  localparam int unsigned LenOutBits   = 24;
  localparam int unsigned CountOutBits = 32;
  localparam int unsigned BaseBits     = 48;

  localparam logic [7:0] ByteLf   = 8'd10;
  localparam logic [7:0] ByteCr   = 8'd13;
  localparam logic [7:0] ByteAt   = 8'h40;
  localparam logic [7:0] BytePlus = 8'h2b;

  localparam logic CmdData  = 1'b0;
  localparam logic CmdStart = 1'b1;

  localparam logic [1:0] LineHeader = 2'd0;
  localparam logic [1:0] LineSeq    = 2'd1;
  localparam logic [1:0] LinePlus   = 2'd2;
  localparam logic [1:0] LineQual   = 2'd3;

  localparam logic [1:0] PlusNone  = 2'd0;
  localparam logic [1:0] PlusExact = 2'd1;
  localparam logic [1:0] PlusOther = 2'd2;

  localparam logic [2:0] VerdictValid    = 3'd0;
  localparam logic [2:0] VerdictHeader   = 3'd1;
  localparam logic [2:0] VerdictPlus     = 3'd2;
  localparam logic [2:0] VerdictEmpty    = 3'd3;
  localparam logic [2:0] VerdictMismatch = 3'd4;

  typedef struct packed {
    logic                    record_done;
    logic [2:0]              verdict;
    logic [LenOutBits-1:0]   record_length;
    logic [CountOutBits-1:0] valid_records;
    logic [BaseBits-1:0]     total_bases;
    logic [CountOutBits-1:0] bad_header_count;
    logic [CountOutBits-1:0] plus_error_count;
    logic [CountOutBits-1:0] empty_seq_count;
    logic [CountOutBits-1:0] mismatch_count;
    logic [CountOutBits-1:0] skipped_lines;
    logic                    all_valid;
  } fqv_result_t;

endpackage

[design/fqv_parser.sv]
// Per-byte line parser, record checker and saturating counters.
`timescale 1ns / 1ps

module fqv_parser #(
  parameter int unsigned LEN_BITS   = 24,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                cmd_i,
  input  logic [7:0]          data_byte_i,
  output fqv_pkg::fqv_result_t result_o
);
  import fqv_pkg::*;

  localparam logic [LEN_BITS-1:0]   LenMax  = '1;
  localparam logic [COUNT_BITS-1:0] CntMax  = '1;
  localparam logic [BaseBits-1:0]   BaseMax = '1;
  localparam logic [LEN_BITS-1:0]   LenOne  = LEN_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CntOne  = COUNT_BITS'(1);

  logic [1:0]            line_idx_q, line_idx_d;
  logic                  at_start_q, at_start_d;
  logic                  past_cr_q, past_cr_d;
  logic                  resync_q, resync_d;
  logic                  header_ok_q, header_ok_d;
  logic [1:0]            plus_q, plus_d;
  logic [LEN_BITS-1:0]   seq_len_q, seq_len_d;
  logic [LEN_BITS-1:0]   qual_len_q, qual_len_d;
  logic [COUNT_BITS-1:0] valid_cnt_q, valid_cnt_d;
  logic [BaseBits-1:0]   base_cnt_q, base_cnt_d;
  logic [COUNT_BITS-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [COUNT_BITS-1:0] plus_cnt_q, plus_cnt_d;
  logic [COUNT_BITS-1:0] empty_cnt_q, empty_cnt_d;
  logic [COUNT_BITS-1:0] mis_cnt_q, mis_cnt_d;
  logic [COUNT_BITS-1:0] skip_cnt_q, skip_cnt_d;
  logic                  all_valid_q, all_valid_d;
  logic                  done;
  logic [2:0]            verdict;
  logic [LEN_BITS-1:0]   rlen;
  logic [BaseBits:0]     base_sum;

  assign base_sum = {1'b0, base_cnt_q} + (BaseBits + 1)'(seq_len_q);

  always_comb begin
    line_idx_d  = line_idx_q;
    at_start_d  = at_start_q;
    past_cr_d   = past_cr_q;
    resync_d    = resync_q;
    header_ok_d = header_ok_q;
    plus_d      = plus_q;
    seq_len_d   = seq_len_q;
    qual_len_d  = qual_len_q;
    valid_cnt_d = valid_cnt_q;
    base_cnt_d  = base_cnt_q;
    hdr_cnt_d   = hdr_cnt_q;
    plus_cnt_d  = plus_cnt_q;
    empty_cnt_d = empty_cnt_q;
    mis_cnt_d   = mis_cnt_q;
    skip_cnt_d  = skip_cnt_q;
    all_valid_d = all_valid_q;
    done        = 1'b0;
    verdict     = VerdictValid;
    rlen        = '0;

    if (cmd_i == CmdStart) begin
      line_idx_d  = LineHeader;
      at_start_d  = 1'b1;
      past_cr_d   = 1'b0;
      resync_d    = 1'b0;
      header_ok_d = 1'b0;
      plus_d      = PlusNone;
      seq_len_d   = '0;
      qual_len_d  = '0;
      valid_cnt_d = '0;
      base_cnt_d  = '0;
      hdr_cnt_d   = '0;
      plus_cnt_d  = '0;
      empty_cnt_d = '0;
      mis_cnt_d   = '0;
      skip_cnt_d  = '0;
      all_valid_d = 1'b1;
    end else if (resync_q) begin
      if (at_start_q) begin
        skip_cnt_d = (skip_cnt_q == CntMax) ? CntMax : skip_cnt_q + CntOne;
        if (data_byte_i == ByteAt) begin
          resync_d    = 1'b0;
          header_ok_d = 1'b1;
          line_idx_d  = LineHeader;
          past_cr_d   = 1'b0;
          at_start_d  = 1'b0;
        end else begin
          at_start_d = (data_byte_i == ByteLf);
        end
      end else if (data_byte_i == ByteLf) begin
        at_start_d = 1'b1;
      end
    end else if (data_byte_i == ByteLf) begin
      if (line_idx_q == LineQual) begin
        done = 1'b1;
        rlen = seq_len_q;
        priority if (!header_ok_q) begin
          verdict   = VerdictHeader;
          hdr_cnt_d = (hdr_cnt_q == CntMax) ? CntMax : hdr_cnt_q + CntOne;
          resync_d  = 1'b1;
        end else if (plus_q != PlusExact) begin
          verdict    = VerdictPlus;
          plus_cnt_d = (plus_cnt_q == CntMax) ? CntMax : plus_cnt_q + CntOne;
        end else if (seq_len_q == '0) begin
          verdict     = VerdictEmpty;
          empty_cnt_d = (empty_cnt_q == CntMax) ? CntMax : empty_cnt_q + CntOne;
        end else if (seq_len_q != qual_len_q) begin
          verdict   = VerdictMismatch;
          mis_cnt_d = (mis_cnt_q == CntMax) ? CntMax : mis_cnt_q + CntOne;
        end else begin
          verdict     = VerdictValid;
          valid_cnt_d = (valid_cnt_q == CntMax) ? CntMax : valid_cnt_q + CntOne;
          base_cnt_d  = base_sum[BaseBits] ? BaseMax : base_sum[BaseBits-1:0];
        end
        if (verdict != VerdictValid) begin
          all_valid_d = 1'b0;
        end
        line_idx_d  = LineHeader;
        header_ok_d = 1'b0;
        plus_d      = PlusNone;
        seq_len_d   = '0;
        qual_len_d  = '0;
      end else begin
        line_idx_d = line_idx_q + 2'd1;
      end
      at_start_d = 1'b1;
      past_cr_d  = 1'b0;
    end else if (past_cr_q) begin
      past_cr_d = past_cr_q;
    end else if (data_byte_i == ByteCr) begin
      past_cr_d  = 1'b1;
      at_start_d = 1'b0;
    end else begin
      unique case (line_idx_q)
        LineHeader: begin
          if (at_start_q) begin
            header_ok_d = (data_byte_i == ByteAt);
          end
        end
        LineSeq: begin
          seq_len_d = (seq_len_q == LenMax) ? LenMax : seq_len_q + LenOne;
        end
        LinePlus: begin
          plus_d = (plus_q == PlusNone && data_byte_i == BytePlus) ? PlusExact : PlusOther;
        end
        default: begin
          qual_len_d = (qual_len_q == LenMax) ? LenMax : qual_len_q + LenOne;
        end
      endcase
      at_start_d = 1'b0;
    end
  end

  always_comb begin
    result_o.record_done      = done;
    result_o.verdict          = verdict;
    result_o.record_length    = LenOutBits'(rlen);
    result_o.valid_records    = CountOutBits'(valid_cnt_d);
    result_o.total_bases      = base_cnt_d;
    result_o.bad_header_count = CountOutBits'(hdr_cnt_d);
    result_o.plus_error_count = CountOutBits'(plus_cnt_d);
    result_o.empty_seq_count  = CountOutBits'(empty_cnt_d);
    result_o.mismatch_count   = CountOutBits'(mis_cnt_d);
    result_o.skipped_lines    = CountOutBits'(skip_cnt_d);
    result_o.all_valid        = all_valid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_idx_q  <= LineHeader;
      at_start_q  <= 1'b1;
      past_cr_q   <= 1'b0;
      resync_q    <= 1'b0;
      header_ok_q <= 1'b0;
      plus_q      <= PlusNone;
      seq_len_q   <= '0;
      qual_len_q  <= '0;
      valid_cnt_q <= '0;
      base_cnt_q  <= '0;
      hdr_cnt_q   <= '0;
      plus_cnt_q  <= '0;
      empty_cnt_q <= '0;
      mis_cnt_q   <= '0;
      skip_cnt_q  <= '0;
      all_valid_q <= 1'b1;
    end else if (en_i) begin
      line_idx_q  <= line_idx_d;
      at_start_q  <= at_start_d;
      past_cr_q   <= past_cr_d;
      resync_q    <= resync_d;
      header_ok_q <= header_ok_d;
      plus_q      <= plus_d;
      seq_len_q   <= seq_len_d;
      qual_len_q  <= qual_len_d;
      valid_cnt_q <= valid_cnt_d;
      base_cnt_q  <= base_cnt_d;
      hdr_cnt_q   <= hdr_cnt_d;
      plus_cnt_q  <= plus_cnt_d;
      empty_cnt_q <= empty_cnt_d;
      mis_cnt_q   <= mis_cnt_d;
      skip_cnt_q  <= skip_cnt_d;
      all_valid_q <= all_valid_d;
    end
  end

endmodule

[design/fqv_out_buf.sv]
// Output register with a skid stage for result transactions.
`timescale 1ns / 1ps

module fqv_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fqv_pkg::fqv_result_t data_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  logic                 stall_i,
  output fqv_pkg::fqv_result_t data_o
);
  import fqv_pkg::*;

  logic        main_valid_q, skid_valid_q;
  fqv_result_t main_q, skid_q;
  logic        pop;

  assign pop     = main_valid_q && !stall_i;
  assign full_o  = skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

endmodule

[design/fastq_record_validator.sv]
// Top level of the FASTQ record validator.
//
//   Channel | Direction | Handshake              | Payload
//   in      | input     | in_valid_i, in_stall_o | cmd_i, data_byte_i
//   out     | output    | out_valid_o, out_stall_i | record_done_o .. all_valid_o
//
// Each byte transaction's result is registered in the result register, so one
// byte per cycle is sustained while the output is not stalled. The parse state and
// counters update in the accepting cycle; the result register with its skid
// stage lets input continue for one transaction while the output is stalled.
// Reset (rst_ni low) clears the parse state, the counters and both output stages.
`timescale 1ns / 1ps

module fastq_record_validator #(
  parameter int unsigned LEN_BITS   = 24,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_done_o,
  output logic [2:0]  verdict_o,
  output logic [23:0] record_length_o,
  output logic [31:0] valid_records_o,
  output logic [47:0] total_bases_o,
  output logic [31:0] bad_header_count_o,
  output logic [31:0] plus_error_count_o,
  output logic [31:0] empty_seq_count_o,
  output logic [31:0] mismatch_count_o,
  output logic [31:0] skipped_lines_o,
  output logic        all_valid_o
);
  import fqv_pkg::*;

  logic        accept;
  logic        full;
  fqv_result_t result;
  fqv_result_t out_data;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  fqv_parser #(
    .LEN_BITS  (LEN_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (accept),
    .cmd_i      (cmd_i),
    .data_byte_i(data_byte_i),
    .result_o   (result)
  );

  fqv_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (result),
    .full_o (full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (out_data)
  );

  assign record_done_o      = out_data.record_done;
  assign verdict_o          = out_data.verdict;
  assign record_length_o    = out_data.record_length;
  assign valid_records_o    = out_data.valid_records;
  assign total_bases_o      = out_data.total_bases;
  assign bad_header_count_o = out_data.bad_header_count;
  assign plus_error_count_o = out_data.plus_error_count;
  assign empty_seq_count_o  = out_data.empty_seq_count;
  assign mismatch_count_o   = out_data.mismatch_count;
  assign skipped_lines_o    = out_data.skipped_lines;
  assign all_valid_o        = out_data.all_valid;

endmodule
